FILE: rtl/aprq_pkg.sv
package aprq_pkg;

    // Fixed field widths of the stream payload
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 4;
    localparam int STAT_W = 2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic ready;
        logic scan;
        logic shift;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_deq;
        logic empty;
        logic scan_last;
        logic no_shift;
        logic shift_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/array_priority_queue.sv
// Bounded priority queue of up to QUEUE_DEPTH entries (tag + priority) held
// unsorted in a one-write, one-read entry RAM. tuser selects the operation:
// 0 enqueues, 1 dequeues the entry with the lowest priority value (ties go to
// the oldest). Every input transaction returns exactly one result carrying a
// status (0 done, 1 full, 2 empty), the dequeued tag and priority (zero
// otherwise) and the occupancy after the operation. An enqueue, or a dequeue
// on an empty queue, goes straight from acceptance to the emit step. A dequeue
// of stored entries first scans them for the minimum, one RAM read per entry,
// then one read/write per later entry to close the gap. One transaction is in
// work at a time; the result waits in an output register, and the next
// transaction may be accepted before it is taken.
module array_priority_queue #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] item_tag, [23:16] item_priority
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] out_tag, [23:16] out_priority,
                                        // [27:24] occupancy, [31:28] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import aprq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    logic [TAG_W-1:0]  out_tag;
    logic [PRIO_W-1:0] out_prio;
    logic [OCC_W-1:0]  out_occ;

    aprq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    aprq_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .i_tag       (s_axis_tdata[15:0]),
        .i_prio      (s_axis_tdata[23:16]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_tag       (out_tag),
        .o_prio      (out_prio),
        .o_occ       (out_occ)
    );

    assign s_axis_tready = cmd.ready;
    assign m_axis_tdata  = {4'b0000, out_occ, out_prio, out_tag};

endmodule

FILE: rtl/aprq_ram.sv
module aprq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/aprq_ctrl.sv
module aprq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aprq_pkg::t_stat i_stat,
    output aprq_pkg::t_cmd  o_cmd
);
    import aprq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = (i_stat.in_deq && !i_stat.empty) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = i_stat.no_shift ? S_EMIT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.ready = 1'b1;
            S_SCAN:  o_cmd.scan  = 1'b1;
            S_SHIFT: o_cmd.shift = 1'b1;
            S_EMIT:  o_cmd.emit  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_stat.in_valid && i_stat.in_deq && !i_stat.empty)
        |=> r_state == S_SCAN)
        else $error("dequeue on a non-empty queue did not start a scan");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_stat.out_free) |=> r_state == S_EMIT)
        else $error("result left before the output register was free");

endmodule

FILE: rtl/aprq_dp.sv
module aprq_dp #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aprq_pkg::t_cmd              i_cmd,
    output aprq_pkg::t_stat             o_stat,
    input  logic                        i_in_valid,
    input  logic                        i_op,
    input  logic [aprq_pkg::TAG_W-1:0]  i_tag,
    input  logic [aprq_pkg::PRIO_W-1:0] i_prio,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [aprq_pkg::STAT_W-1:0] o_status,
    output logic [aprq_pkg::TAG_W-1:0]  o_tag,
    output logic [aprq_pkg::PRIO_W-1:0] o_prio,
    output logic [aprq_pkg::OCC_W-1:0]  o_occ
);
    import aprq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DW = TAG_BITS + PRIORITY_BITS;

    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_widx;
    logic [AW-1:0]            r_best_idx;
    logic [TAG_BITS-1:0]      r_best_tag;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic                     r_op_deq;
    t_status                  r_pend_status;

    logic                     r_m_valid;
    t_status                  r_out_status;
    logic [TAG_W-1:0]         r_out_tag;
    logic [PRIO_W-1:0]        r_out_prio;
    logic [OCC_W-1:0]         r_out_occ;

    logic [AW-1:0]            n_best_idx;
    logic [TAG_BITS-1:0]      n_best_tag;
    logic [PRIORITY_BITS-1:0] n_best_prio;

    logic [DW-1:0]            ram_rdata;
    logic [TAG_BITS-1:0]      rd_tag;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DW-1:0]            ram_wdata;
    logic [AW-1:0]            ram_raddr;

    logic accept;
    logic full;
    logic empty;
    logic upd;
    logic scan_last;
    logic no_shift;
    logic shift_last;
    logic enq_ok;
    logic out_free;

    assign rd_tag  = ram_rdata[TAG_BITS-1:0];
    assign rd_prio = ram_rdata[DW-1:TAG_BITS];

    assign accept   = i_cmd.ready & i_in_valid;
    assign full     = (r_count == CW'(QUEUE_DEPTH));
    assign empty    = (r_count == '0);
    assign enq_ok   = accept && (i_op == OP_ENQ) && !full;
    assign out_free = !r_m_valid || i_out_ready;

    // first entry seeds the minimum; strict compare keeps the earliest on a tie
    assign upd         = (r_idx == '0) || (rd_prio < r_best_prio);
    assign n_best_idx  = upd ? r_idx   : r_best_idx;
    assign n_best_tag  = upd ? rd_tag  : r_best_tag;
    assign n_best_prio = upd ? rd_prio : r_best_prio;

    assign scan_last  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign no_shift   = ((CW'(n_best_idx) + CW'(1)) == r_count);
    assign shift_last = ((CW'(r_widx) + CW'(2)) == r_count);

    // read one ahead: rdata during a scan is entry r_idx, during a shift entry r_widx+1
    always_comb begin
        if (i_cmd.shift) begin
            ram_raddr = AW'(CW'(r_widx) + CW'(2));
        end else if (i_cmd.scan) begin
            ram_raddr = scan_last ? AW'(CW'(n_best_idx) + CW'(1))
                                  : AW'(CW'(r_idx) + CW'(1));
        end else begin
            ram_raddr = '0;
        end
    end

    assign ram_we    = enq_ok | i_cmd.shift;
    assign ram_waddr = i_cmd.shift ? r_widx : AW'(r_count);
    assign ram_wdata = i_cmd.shift ? ram_rdata
                                   : {PRIORITY_BITS'(i_prio), TAG_BITS'(i_tag)};

    aprq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (enq_ok) begin
                r_count <= r_count + CW'(1);
            end else if ((i_cmd.scan && scan_last && no_shift) ||
                         (i_cmd.shift && shift_last)) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op_deq <= (i_op == OP_DEQ);
            r_idx    <= '0;
            if (i_op == OP_ENQ) begin
                r_pend_status <= full ? ST_FULL : ST_DONE;
            end else begin
                r_pend_status <= empty ? ST_EMPTY : ST_DONE;
            end
        end
        if (i_cmd.scan) begin
            r_idx       <= AW'(CW'(r_idx) + CW'(1));
            r_best_idx  <= n_best_idx;
            r_best_tag  <= n_best_tag;
            r_best_prio <= n_best_prio;
            r_widx      <= n_best_idx;
        end else if (i_cmd.shift) begin
            r_widx <= AW'(CW'(r_widx) + CW'(1));
        end
        if (i_cmd.emit) begin
            r_out_status <= r_pend_status;
            r_out_occ    <= OCC_W'(r_count);
            if (r_op_deq && r_pend_status == ST_DONE) begin
                r_out_tag  <= TAG_W'(r_best_tag);
                r_out_prio <= PRIO_W'(r_best_prio);
            end else begin
                r_out_tag  <= '0;
                r_out_prio <= '0;
            end
        end
    end

    assign o_stat.in_valid   = i_in_valid;
    assign o_stat.in_deq     = (i_op == OP_DEQ);
    assign o_stat.empty      = empty;
    assign o_stat.scan_last  = scan_last;
    assign o_stat.no_shift   = no_shift;
    assign o_stat.shift_last = shift_last;
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_m_valid;
    assign o_status    = r_out_status;
    assign o_tag       = r_out_tag;
    assign o_prio      = r_out_prio;
    assign o_occ       = r_out_occ;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (CW'(r_idx) < r_count))
        else $error("scan index past the stored entries");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> ((CW'(r_widx) + CW'(1)) < r_count))
        else $error("compaction reads beyond the stored entries");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(i_cmd.emit))
        else $error("result presented without a completed operation");

endmodule
